>>> rtl/capture_compare_timer_b_macros.svh
// Assertion macros used by the checker file of the timer.
`ifndef CAPTURE_COMPARE_TIMER_B_MACROS_SVH
`define CAPTURE_COMPARE_TIMER_B_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CCB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer check failed: next-cycle implication");

`endif

>>> rtl/ccb_pkg.sv
package ccb_pkg;

    localparam int COUNT_BITS = 16;

    localparam logic [2:0] ITEM_WRITE    = 3'd0;
    localparam logic [2:0] ITEM_READ     = 3'd1;
    localparam logic [2:0] ITEM_CLOCK    = 3'd2;
    localparam logic [2:0] ITEM_CAPTURE  = 3'd3;
    localparam logic [2:0] ITEM_COUNT    = 3'd4;
    localparam logic [2:0] ITEM_UPSTREAM = 3'd5;

    localparam logic [3:0] OFS_CTRLA    = 4'd0;
    localparam logic [3:0] OFS_CTRLB    = 4'd1;
    localparam logic [3:0] OFS_EVCTRL   = 4'd4;
    localparam logic [3:0] OFS_INTCTRL  = 4'd5;
    localparam logic [3:0] OFS_INTFLAGS = 4'd6;
    localparam logic [3:0] OFS_STATUS   = 4'd7;
    localparam logic [3:0] OFS_TEMP     = 4'd9;
    localparam logic [3:0] OFS_CNTL     = 4'd10;
    localparam logic [3:0] OFS_CNTH     = 4'd11;
    localparam logic [3:0] OFS_CCMPL    = 4'd12;
    localparam logic [3:0] OFS_CCMPH    = 4'd13;

    localparam logic [2:0] CNT_INT     = 3'd0;
    localparam logic [2:0] CNT_TIMEOUT = 3'd1;
    localparam logic [2:0] CNT_CAPT    = 3'd2;
    localparam logic [2:0] CNT_FRQ     = 3'd3;
    localparam logic [2:0] CNT_PW      = 3'd4;
    localparam logic [2:0] CNT_FRQPW   = 3'd5;
    localparam logic [2:0] CNT_SINGLE  = 3'd6;
    localparam logic [2:0] CNT_PWM8    = 3'd7;

    localparam logic [3:0] CK_DIV1  = 4'd0;
    localparam logic [3:0] CK_DIV2  = 4'd1;
    localparam logic [3:0] CK_UP    = 4'd2;
    localparam logic [3:0] CK_EVENT = 4'd7;
    localparam logic [3:0] CK_OFF   = 4'd8;

    localparam logic CFG_OVF_PRESENT   = 1'b0;
    localparam logic CFG_EVCNT_PRESENT = 1'b1;

    localparam logic [7:0] CTRLA_MASK  = 8'h6F;
    localparam logic [7:0] CTRLB_MASK  = 8'h77;
    localparam logic [7:0] EVCTRL_MASK = 8'h51;

    localparam int FLAG_CAPT = 0;
    localparam int FLAG_OVF  = 1;

    typedef enum logic [2:0] {
        PH_RUN   = 3'b001,
        PH_READY = 3'b010,
        PH_END   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] reg_offset;
        logic [7:0] write_byte;
        logic       event_level;
    } item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       wave_level;
        logic       wave_enable;
        logic       capture_flag;
        logic       overflow_flag;
        logic       irq;
        logic       running;
    } result_t;

endpackage

>>> rtl/ccb_core.sv
module ccb_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic             cfg_data,
    input  logic             fire,
    input  ccb_pkg::item_t   item,
    output ccb_pkg::result_t result_next
);
    import ccb_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                  ovf_present_reg;
    logic                  evcnt_present_reg;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [15:0]           ccmp_reg, ccmp_next;
    logic [7:0]            temp_reg, temp_next;
    logic [7:0]            ctrla_reg, ctrla_next;
    logic [7:0]            ctrlb_reg, ctrlb_next;
    logic [7:0]            evctrl_reg, evctrl_next;
    logic [1:0]            inten_reg, inten_next;
    logic [1:0]            flags_reg, flags_next;
    phase_t                phase_reg, phase_next;
    logic                  last_lvl_reg, last_lvl_next;
    logic                  wave_reg, wave_next;
    logic                  div_reg, div_next;

    logic [1:0]            fmask;
    logic [2:0]            cmode;
    logic [2:0]            new_cmode;
    logic [3:0]            ck;
    logic [3:0]            new_ck;
    logic                  running;
    logic                  tick;
    logic [COUNT_BITS-1:0] top;
    logic                  at_top;
    logic                  bottom;
    logic                  ovf;
    logic                  cmp;
    logic                  ev_edge;
    logic [31:0]           cnt_wide;
    logic [7:0]            rd;
    logic [7:0]            new_ctrla;
    logic [7:0]            new_ctrlb;
    logic [1:0]            fl;

    always_comb
    begin
        fmask    = ovf_present_reg ? 2'b11 : 2'b01;
        cmode    = ctrlb_reg[2:0];
        ck       = ctrla_reg[0] ? {1'b0, ctrla_reg[3:1]} : CK_OFF;
        running  = ctrla_reg[0] && (phase_reg == PH_RUN);
        cnt_wide = 32'(cnt_reg);

        cnt_next      = cnt_reg;
        ccmp_next     = ccmp_reg;
        temp_next     = temp_reg;
        ctrla_next    = ctrla_reg;
        ctrlb_next    = ctrlb_reg;
        evctrl_next   = evctrl_reg;
        inten_next    = inten_reg;
        flags_next    = flags_reg;
        phase_next    = phase_reg;
        last_lvl_next = last_lvl_reg;
        wave_next     = wave_reg;
        div_next      = div_reg;
        rd            = 8'h00;
        tick          = 1'b0;
        ev_edge       = 1'b0;
        new_ctrla     = item.write_byte & CTRLA_MASK;
        new_ctrlb     = item.write_byte & CTRLB_MASK;
        new_cmode     = new_ctrlb[2:0];
        new_ck        = new_ctrla[0] ? {1'b0, new_ctrla[3:1]} : CK_OFF;

        case (item.mode)
            ITEM_WRITE:
            begin
                case (item.reg_offset)
                    OFS_CTRLA:
                    begin
                        ctrla_next = new_ctrla;
                        if (new_ck != ck)
                        begin
                            div_next = 1'b0;
                        end
                    end
                    OFS_CTRLB:
                    begin
                        ctrlb_next = new_ctrlb;
                        if (new_cmode == CNT_TIMEOUT || new_cmode == CNT_FRQPW
                            || new_cmode == CNT_SINGLE)
                        begin
                            phase_next = PH_READY;
                        end
                        else
                        begin
                            phase_next = PH_RUN;
                        end
                        if (new_cmode == CNT_SINGLE || new_cmode == CNT_PWM8)
                        begin
                            wave_next = 1'b0;
                        end
                        else
                        begin
                            wave_next = new_ctrlb[5];
                        end
                    end
                    OFS_EVCTRL:   evctrl_next = item.write_byte & EVCTRL_MASK;
                    OFS_INTCTRL:  inten_next = item.write_byte[1:0] & fmask;
                    OFS_INTFLAGS:
                    begin
                        if (item.write_byte[FLAG_CAPT])
                        begin
                            flags_next[FLAG_CAPT] = 1'b0;
                        end
                        if (item.write_byte[FLAG_OVF] && ovf_present_reg)
                        begin
                            flags_next[FLAG_OVF] = 1'b0;
                        end
                    end
                    OFS_TEMP, OFS_CNTL, OFS_CCMPL: temp_next = item.write_byte;
                    OFS_CNTH:  cnt_next = COUNT_BITS'({item.write_byte, temp_reg});
                    OFS_CCMPH: ccmp_next = {item.write_byte, temp_reg};
                    default:   ;
                endcase
            end
            ITEM_READ:
            begin
                case (item.reg_offset)
                    OFS_CTRLA:    rd = ctrla_reg;
                    OFS_CTRLB:    rd = ctrlb_reg;
                    OFS_EVCTRL:   rd = evctrl_reg;
                    OFS_INTCTRL:  rd = {6'b0, inten_reg & fmask};
                    OFS_INTFLAGS: rd = {6'b0, flags_reg & fmask};
                    OFS_STATUS:   rd = {7'b0, running};
                    OFS_TEMP:     rd = temp_reg;
                    OFS_CNTL:
                    begin
                        temp_next = cnt_wide[15:8];
                        rd        = cnt_wide[7:0];
                    end
                    OFS_CCMPL:
                    begin
                        temp_next = ccmp_reg[15:8];
                        if (cmode == CNT_CAPT || cmode == CNT_FRQ || cmode == CNT_PW
                            || cmode == CNT_FRQPW)
                        begin
                            flags_next[FLAG_CAPT] = 1'b0;
                        end
                        if (cmode == CNT_FRQPW && phase_reg == PH_END)
                        begin
                            phase_next = PH_READY;
                        end
                        rd = ccmp_reg[7:0];
                    end
                    OFS_CNTH, OFS_CCMPH: rd = temp_reg;
                    default:             rd = 8'h00;
                endcase
            end
            ITEM_CLOCK:
            begin
                if (ck == CK_DIV1)
                begin
                    tick = running;
                end
                else if (ck == CK_DIV2)
                begin
                    div_next = ~div_reg;
                    tick     = div_reg && running;
                end
            end
            ITEM_CAPTURE:
            begin
                if (item.event_level != last_lvl_reg)
                begin
                    last_lvl_next = item.event_level;
                    if (ctrla_reg[0] && evctrl_reg[0])
                    begin
                        if (cmode == CNT_SINGLE)
                        begin
                            ev_edge = evctrl_reg[4] || item.event_level;
                        end
                        else
                        begin
                            ev_edge = evctrl_reg[4] ? !item.event_level : item.event_level;
                        end
                        case (cmode)
                            CNT_TIMEOUT:
                            begin
                                if (ev_edge)
                                begin
                                    cnt_next   = '0;
                                    phase_next = PH_RUN;
                                end
                                else
                                begin
                                    phase_next = PH_READY;
                                end
                            end
                            CNT_CAPT:
                            begin
                                if (ev_edge)
                                begin
                                    ccmp_next             = cnt_wide[15:0];
                                    flags_next[FLAG_CAPT] = 1'b1;
                                end
                            end
                            CNT_FRQ:
                            begin
                                if (ev_edge)
                                begin
                                    ccmp_next             = cnt_wide[15:0];
                                    cnt_next              = '0;
                                    flags_next[FLAG_CAPT] = 1'b1;
                                end
                            end
                            CNT_PW:
                            begin
                                if (ev_edge)
                                begin
                                    cnt_next = '0;
                                end
                                else
                                begin
                                    ccmp_next             = cnt_wide[15:0];
                                    flags_next[FLAG_CAPT] = 1'b1;
                                end
                            end
                            CNT_FRQPW:
                            begin
                                if (ev_edge)
                                begin
                                    if (phase_reg == PH_READY)
                                    begin
                                        phase_next = PH_RUN;
                                        cnt_next   = '0;
                                    end
                                    else if (phase_reg == PH_RUN)
                                    begin
                                        phase_next            = PH_END;
                                        flags_next[FLAG_CAPT] = 1'b1;
                                    end
                                end
                                else if (phase_reg == PH_RUN)
                                begin
                                    ccmp_next = cnt_wide[15:0];
                                end
                            end
                            CNT_SINGLE:
                            begin
                                if (ev_edge && phase_reg == PH_READY)
                                begin
                                    phase_next = PH_RUN;
                                    cnt_next   = '0;
                                    wave_next  = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ITEM_COUNT:    tick = evcnt_present_reg && (ck == CK_EVENT) && running;
            ITEM_UPSTREAM: tick = (ck == CK_UP) && running;
            default:       ;
        endcase

        // Counter advance; it acts only when an item raises tick, and may also set flags, the wave level and the phase.
        if (cmode == CNT_INT || cmode == CNT_SINGLE)
        begin
            top = COUNT_BITS'(ccmp_reg);
        end
        else if (cmode == CNT_PWM8)
        begin
            top = COUNT_BITS'(ccmp_reg[7:0]);
        end
        else
        begin
            top = COUNT_MAX;
        end
        at_top = 1'b0;
        bottom = 1'b0;
        ovf    = 1'b0;
        cmp    = 1'b0;
        if (tick)
        begin
            if (cnt_reg == top)
            begin
                cnt_next = '0;
                at_top   = 1'b1;
                bottom   = 1'b1;
                ovf      = (cnt_reg == COUNT_MAX);
            end
            else if (cnt_reg == COUNT_MAX)
            begin
                cnt_next = '0;
                bottom   = 1'b1;
                ovf      = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            if (cmode == CNT_TIMEOUT)
            begin
                cmp = (cnt_next == COUNT_BITS'(ccmp_reg));
            end
            else if (cmode == CNT_PWM8)
            begin
                cmp = (32'(cnt_next) == 32'(ccmp_reg[15:8]));
            end
            if (at_top)
            begin
                if (cmode == CNT_INT || cmode == CNT_PWM8)
                begin
                    flags_next[FLAG_CAPT] = 1'b1;
                end
                else if (cmode == CNT_SINGLE)
                begin
                    flags_next[FLAG_CAPT] = 1'b1;
                    wave_next             = 1'b0;
                    phase_next            = PH_READY;
                end
            end
            if (bottom && cmode == CNT_PWM8)
            begin
                wave_next = 1'b1;
            end
            if (cmp)
            begin
                if (cmode == CNT_TIMEOUT)
                begin
                    flags_next[FLAG_CAPT] = 1'b1;
                end
                else
                begin
                    wave_next = 1'b0;
                end
            end
            if (ovf && ovf_present_reg)
            begin
                flags_next[FLAG_OVF] = 1'b1;
            end
        end

        fl                        = flags_next & fmask;
        result_next.read_byte     = rd;
        result_next.wave_level    = wave_next;
        result_next.wave_enable   = ctrla_next[0] && ctrlb_next[4];
        result_next.capture_flag  = fl[FLAG_CAPT];
        result_next.overflow_flag = fl[FLAG_OVF];
        result_next.irq           = |(fl & inten_next);
        result_next.running       = ctrla_next[0] && (phase_next == PH_RUN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_present_reg   <= 1'b0;
            evcnt_present_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_OVF_PRESENT)
            begin
                ovf_present_reg <= cfg_data;
            end
            if (cfg_index == CFG_EVCNT_PRESENT)
            begin
                evcnt_present_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            ccmp_reg     <= '0;
            temp_reg     <= '0;
            ctrla_reg    <= '0;
            ctrlb_reg    <= '0;
            evctrl_reg   <= '0;
            inten_reg    <= '0;
            flags_reg    <= '0;
            phase_reg    <= PH_RUN;
            last_lvl_reg <= 1'b0;
            wave_reg     <= 1'b0;
            div_reg      <= 1'b0;
        end
        else if (fire)
        begin
            cnt_reg      <= cnt_next;
            ccmp_reg     <= ccmp_next;
            temp_reg     <= temp_next;
            ctrla_reg    <= ctrla_next;
            ctrlb_reg    <= ctrlb_next;
            evctrl_reg   <= evctrl_next;
            inten_reg    <= inten_next;
            flags_reg    <= flags_next;
            phase_reg    <= phase_next;
            last_lvl_reg <= last_lvl_next;
            wave_reg     <= wave_next;
            div_reg      <= div_next;
        end
    end

endmodule

>>> rtl/capture_compare_timer_b.sv
// Path: an item is captured in the input register, then one pass of the timer logic
// writes its result into the result register.
// Throughput: one item per cycle while the result is not stalled; a stalled result
// holds the input register and stalls the input.
// Reset: asynchronous, active low; all timer state and both options clear.
module capture_compare_timer_b (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic             cfg_data,
    input  logic             item_valid,
    output logic             item_stall,
    input  ccb_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output ccb_pkg::result_t result
);
    import ccb_pkg::*;

    item_t   item_reg;
    logic    item_valid_reg, item_valid_next;
    result_t result_reg;
    logic    result_valid_reg, result_valid_next;
    result_t result_next;
    logic    advance;
    logic    take;

    ccb_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fire        (advance),
        .item        (item_reg),
        .result_next (result_next)
    );

    always_comb
    begin
        advance    = item_valid_reg && (!result_valid_reg || !result_stall);
        item_stall = item_valid_reg && !advance;
        take       = item_valid && !item_stall;

        item_valid_next = item_valid_reg;
        if (take)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/ccb_checker.sv
`include "capture_compare_timer_b_macros.svh"

module ccb_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input ccb_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input ccb_pkg::result_t result
);
    import ccb_pkg::*;

    logic item_xfer;

    assign item_xfer = item_valid && !item_stall && (item.mode == item.mode);

    `CCB_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
    `CCB_ASSERT_SAME(a_irq_has_flag, result_valid, !result.irq || result.capture_flag || result.overflow_flag)
    `CCB_ASSERT_SAME(a_result_from_item, $rose(result_valid), $past(item_xfer, 2))
    `CCB_ASSERT_SAME(a_empty_no_stall, !result_valid, !item_stall)

endmodule

bind capture_compare_timer_b ccb_checker u_ccb_checker (.*);
